FILE: sv/wvbh_pkg.sv
`timescale 1ns / 1ps

package wvbh_pkg;

  localparam int HEADER_BYTES   = 32;
  localparam int FRAME_LEN_BITS = 24;
  localparam int SIMPLE_HDR_BYTES = 20;
  localparam int CNT_BITS = $clog2(HEADER_BYTES + 2);

  localparam logic [7:0] CHAR_W = 8'h77;
  localparam logic [7:0] CHAR_V = 8'h76;
  localparam logic [7:0] CHAR_P = 8'h70;
  localparam logic [7:0] CHAR_K = 8'h6b;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Size fields in the headers are the byte count plus these offsets.
  localparam logic [31:0] SIMPLE_SIZE_ADD = 32'(HEADER_BYTES - 20);
  localparam logic [31:0] MULTI_SIZE_ADD  = 32'(HEADER_BYTES - 8);

  localparam logic [3:0] TRIPLE_BYTES  = 4'd12;
  localparam logic [7:0] SIMPLE_MAX_CH = 8'd2;

  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_CODEC_VERSION = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 1'd1;

  localparam logic [15:0] CODEC_VERSION_RST = 16'd1040;
  localparam logic [7:0]  CHANNEL_COUNT_RST = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIMPLE,
    PH_COUNT,
    PH_TRIPLE,
    PH_PAYLOAD,
    PH_DROP
  } phase_t;

  // Replace byte sel of a little-endian word.
  function automatic logic [31:0] set_byte(input logic [31:0] word, input logic [1:0] sel,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    case (sel)
      2'd0: w[7:0]   = b;
      2'd1: w[15:8]  = b;
      2'd2: w[23:16] = b;
      2'd3: w[31:24] = b;
      default: w = word;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/wvbh_if.sv
`timescale 1ns / 1ps

interface wvbh_in_if;
  logic                                valid;
  logic                                ready;
  logic [7:0]                          in_byte;
  logic                                frame_start;
  logic [wvbh_pkg::FRAME_LEN_BITS-1:0] frame_bytes;

  modport source (output valid, output in_byte, output frame_start, output frame_bytes,
                  input ready);
  modport sink (input valid, input in_byte, input frame_start, input frame_bytes,
                output ready);
endinterface

interface wvbh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_error;
  logic       run_last;

  modport source (output valid, output out_byte, output is_error, output run_last,
                  input ready);
  modport sink (input valid, input out_byte, input is_error, input run_last,
                output ready);
endinterface

interface wvbh_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wvbh_pkg::CFG_IDX_BITS-1:0]  index;
  logic [wvbh_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/wavpack_block_header_rebuild_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                              Handshake
// din      in   in_byte, frame_start, frame_bytes    valid/ready
// dout     out  out_byte, is_error, run_last         valid/ready
// cfg      in   index, data                          valid/ready (always ready)
//
// Each input byte is parsed in the cycle it is accepted; its results are then
// played out of a descriptor register, one byte per cycle while dout is ready.
// Pass-through bytes run the input at one byte per cycle while dout is ready.
// A frame start in simple mode gives a 21-byte burst and a completed sub-block
// header gives a 32-byte burst; the input stalls until the last byte of a burst is taken.
// Synchronous reset clears the parser state, the block index and the burst.

module wavpack_block_header_rebuild_unit (
  input logic         clk,
  input logic         rst,
  wvbh_in_if.sink     din,
  wvbh_out_if.source  dout,
  wvbh_cfg_if.sink    cfg
);

  localparam int FLB = wvbh_pkg::FRAME_LEN_BITS;
  localparam int CB  = wvbh_pkg::CNT_BITS;

  logic [15:0] codec_version;
  logic [7:0]  channel_count;

  wvbh_pkg::phase_t phase, phase_next;
  logic [31:0]    run_idx, run_idx_next;
  logic [FLB-1:0] seen, seen_next;
  logic [FLB-1:0] flen, flen_next;
  logic [FLB-1:0] left, left_next;
  logic [31:0]    samples, samples_next;
  logic [31:0]    flags, flags_next;
  logic [31:0]    crc, crc_next;
  logic [31:0]    size, size_next;
  logic [FLB-1:0] rem;

  // Results of the byte being accepted.
  logic [CB-1:0] res_hdr_len;
  logic          res_has_byte;
  logic          res_err;
  logic [7:0]    res_data;
  logic [31:0]   res_ck;

  // Burst descriptor.
  logic          busy;
  logic [CB-1:0] cnt;
  logic [CB-1:0] d_hdr_len;
  logic          d_has_byte;
  logic          d_err;
  logic [7:0]    d_data;
  logic [31:0]   d_ck;
  logic [31:0]   d_idx;
  logic [31:0]   d_samples;
  logic [31:0]   d_flags;
  logic [31:0]   d_crc;

  logic          take;
  logic          emit;
  logic          last;
  logic [CB-1:0] total;
  logic [31:0]   hdr_words [8];
  logic [31:0]   word_sel;
  logic [7:0]    hdr_byte;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_version <= wvbh_pkg::CODEC_VERSION_RST;
      channel_count <= wvbh_pkg::CHANNEL_COUNT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        wvbh_pkg::REG_CODEC_VERSION: codec_version <= cfg.data[15:0];
        wvbh_pkg::REG_CHANNEL_COUNT: channel_count <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  assign total = d_hdr_len + CB'(d_has_byte);
  assign last  = (cnt == total - CB'(1));
  assign din.ready = !busy || (dout.ready && last);
  assign take = din.valid && din.ready;

  always_comb begin
    phase_next   = phase;
    run_idx_next = run_idx;
    seen_next    = seen;
    flen_next    = flen;
    left_next    = left;
    samples_next = samples;
    flags_next   = flags;
    crc_next     = crc;
    size_next    = size;
    rem          = '0;
    res_hdr_len  = '0;
    res_has_byte = 1'b0;
    res_err      = 1'b0;
    res_data     = din.in_byte;
    res_ck       = '0;

    if (take) begin
      if (din.frame_start) begin
        flen_next    = din.frame_bytes;
        seen_next    = '0;
        samples_next = '0;
        left_next    = '0;
        if (din.frame_bytes < FLB'(4)) begin
          res_has_byte = 1'b1;
          res_err      = 1'b1;
          res_data     = 8'h00;
          phase_next   = wvbh_pkg::PH_IDLE;
        end else if (channel_count <= wvbh_pkg::SIMPLE_MAX_CH) begin
          res_hdr_len = CB'(wvbh_pkg::SIMPLE_HDR_BYTES);
          res_ck      = 32'(din.frame_bytes) + wvbh_pkg::SIMPLE_SIZE_ADD;
          phase_next  = wvbh_pkg::PH_SIMPLE;
        end else begin
          phase_next = wvbh_pkg::PH_COUNT;
        end
      end

      case (phase_next)
        wvbh_pkg::PH_SIMPLE: begin
          if (seen_next < FLB'(4)) begin
            samples_next = wvbh_pkg::set_byte(samples_next, seen_next[1:0], din.in_byte);
          end
          res_has_byte = 1'b1;
          seen_next    = seen_next + FLB'(1);
          if (seen_next == flen_next) begin
            run_idx_next = run_idx + samples_next;
            phase_next   = wvbh_pkg::PH_IDLE;
          end
        end
        wvbh_pkg::PH_COUNT: begin
          samples_next = wvbh_pkg::set_byte(samples_next, seen_next[1:0], din.in_byte);
          seen_next    = seen_next + FLB'(1);
          if (seen_next == FLB'(4)) begin
            rem = flen_next - seen_next;
            if (rem > FLB'(12)) begin
              phase_next = wvbh_pkg::PH_TRIPLE;
              left_next  = '0;
              flags_next = '0;
              crc_next   = '0;
              size_next  = '0;
            end else if (rem == '0) begin
              run_idx_next = run_idx + samples_next;
              phase_next   = wvbh_pkg::PH_IDLE;
            end else begin
              phase_next = wvbh_pkg::PH_DROP;
            end
          end
        end
        wvbh_pkg::PH_TRIPLE: begin
          if (left_next < FLB'(4)) begin
            flags_next = wvbh_pkg::set_byte(flags_next, left_next[1:0], din.in_byte);
          end else if (left_next < FLB'(8)) begin
            crc_next = wvbh_pkg::set_byte(crc_next, left_next[1:0], din.in_byte);
          end else begin
            size_next = wvbh_pkg::set_byte(size_next, left_next[1:0], din.in_byte);
          end
          left_next = left_next + FLB'(1);
          seen_next = seen_next + FLB'(1);
          if (left_next == FLB'(wvbh_pkg::TRIPLE_BYTES)) begin
            rem = flen_next - seen_next;
            if (size_next == '0 || 32'(rem) < size_next) begin
              res_has_byte = 1'b1;
              res_err      = 1'b1;
              res_data     = 8'h00;
              phase_next   = wvbh_pkg::PH_IDLE;
            end else begin
              res_hdr_len = CB'(wvbh_pkg::HEADER_BYTES);
              res_ck      = size_next + wvbh_pkg::MULTI_SIZE_ADD;
              // The size has passed the bound check, so it fits the counter.
              left_next   = size_next[FLB-1:0];
              phase_next  = wvbh_pkg::PH_PAYLOAD;
            end
          end
        end
        wvbh_pkg::PH_PAYLOAD: begin
          res_has_byte = 1'b1;
          left_next    = left_next - FLB'(1);
          seen_next    = seen_next + FLB'(1);
          if (left_next == '0) begin
            rem = flen_next - seen_next;
            if (rem > FLB'(12)) begin
              phase_next = wvbh_pkg::PH_TRIPLE;
              left_next  = '0;
              flags_next = '0;
              crc_next   = '0;
              size_next  = '0;
            end else if (rem == '0) begin
              run_idx_next = run_idx + samples_next;
              phase_next   = wvbh_pkg::PH_IDLE;
            end else begin
              phase_next = wvbh_pkg::PH_DROP;
            end
          end
        end
        wvbh_pkg::PH_DROP: begin
          seen_next = seen_next + FLB'(1);
          if (seen_next == flen_next) begin
            run_idx_next = run_idx + samples_next;
            phase_next   = wvbh_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  assign emit = take && (res_has_byte || (res_hdr_len != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= wvbh_pkg::PH_IDLE;
      run_idx <= '0;
      seen    <= '0;
      flen    <= '0;
      left    <= '0;
      samples <= '0;
      flags   <= '0;
      crc     <= '0;
      size    <= '0;
      busy    <= 1'b0;
      cnt     <= '0;
    end else begin
      phase   <= phase_next;
      run_idx <= run_idx_next;
      seen    <= seen_next;
      flen    <= flen_next;
      left    <= left_next;
      samples <= samples_next;
      flags   <= flags_next;
      crc     <= crc_next;
      size    <= size_next;
      if (emit) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy && dout.ready) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + CB'(1);
        end
      end
    end
  end

  // The block index in a header is the value before this byte's update:
  // a frame never finishes on the byte that emits a header.
  always_ff @(posedge clk) begin
    if (emit) begin
      d_hdr_len  <= res_hdr_len;
      d_has_byte <= res_has_byte;
      d_err      <= res_err;
      d_data     <= res_data;
      d_ck       <= res_ck;
      d_idx      <= run_idx;
      d_samples  <= samples_next;
      d_flags    <= flags_next;
      d_crc      <= crc_next;
    end
  end

  always_comb begin
    hdr_words[0] = {wvbh_pkg::CHAR_K, wvbh_pkg::CHAR_P, wvbh_pkg::CHAR_V, wvbh_pkg::CHAR_W};
    hdr_words[1] = d_ck;
    hdr_words[2] = {16'h0000, codec_version};
    hdr_words[3] = wvbh_pkg::ALL_ONES;
    hdr_words[4] = d_idx;
    hdr_words[5] = d_samples;
    hdr_words[6] = d_flags;
    hdr_words[7] = d_crc;
    word_sel = hdr_words[cnt[4:2]];
    case (cnt[1:0])
      2'd0: hdr_byte = word_sel[7:0];
      2'd1: hdr_byte = word_sel[15:8];
      2'd2: hdr_byte = word_sel[23:16];
      2'd3: hdr_byte = word_sel[31:24];
      default: hdr_byte = word_sel[7:0];
    endcase
  end

  assign dout.valid    = busy;
  assign dout.out_byte = (cnt < d_hdr_len) ? hdr_byte : d_data;
  assign dout.is_error = d_err;
  assign dout.run_last = last;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int FLB = wvbh_pkg::FRAME_LEN_BITS;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } stream_byte_t;

  bit   clk;
  logic rst;

  wvbh_in_if  din ();
  wvbh_out_if dout ();
  wvbh_cfg_if cfg ();

  wavpack_block_header_rebuild_unit dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .cfg  (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Copy of the block's registers and parser state, advanced on every accepted item.
  logic [15:0] version;
  logic [7:0]  chans;
  logic [31:0] blk_index, samples, flags, crc, sub_size, left, seen, flen;
  wvbh_pkg::phase_t phase;

  stream_byte_t burst[$];
  stream_byte_t rebuilt_q[$];
  stream_byte_t want, got;
  logic [7:0]   frame_buf[$];

  int src_idle_pct, snk_stall_pct, rx_hold;
  int quiet, fail_count, bytes_in, bytes_out, error_items, frames_sent;

  function automatic void push_byte(input logic [7:0] b, input logic err);
    burst.push_back('{data: b, err: err, last: 1'b0});
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8], 1'b0);
  endfunction

  function automatic void push_header(input logic [31:0] size);
    push_byte(wvbh_pkg::CHAR_W, 1'b0);
    push_byte(wvbh_pkg::CHAR_V, 1'b0);
    push_byte(wvbh_pkg::CHAR_P, 1'b0);
    push_byte(wvbh_pkg::CHAR_K, 1'b0);
    push_word(size);
    push_byte(version[7:0], 1'b0);
    push_byte(version[15:8], 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_word(wvbh_pkg::ALL_ONES);
    push_word(blk_index);
  endfunction

  function automatic void fail_frame();
    push_byte(8'h00, 1'b1);
    phase = wvbh_pkg::PH_IDLE;
  endfunction

  function automatic void finish_frame();
    blk_index = blk_index + samples;
    phase = wvbh_pkg::PH_IDLE;
  endfunction

  function automatic void after_block();
    logic [31:0] rem;
    rem = flen - seen;
    if (rem > 32'(wvbh_pkg::TRIPLE_BYTES)) begin
      phase = wvbh_pkg::PH_TRIPLE;
      left = '0;
      flags = '0;
      crc = '0;
      sub_size = '0;
    end else if (rem == 0) begin
      finish_frame();
    end else begin
      phase = wvbh_pkg::PH_DROP;
    end
  endfunction

  // Works out the stream bytes that one accepted frame byte gives.
  function automatic void rebuild_step(input logic [7:0] b, input logic st,
                                       input logic [FLB-1:0] fb);
    logic [31:0] k, rem;
    burst.delete();
    if (st) begin
      flen = 32'(fb);
      seen = '0;
      samples = '0;
      left = '0;
      if (flen < 4) fail_frame();
      else if (chans <= wvbh_pkg::SIMPLE_MAX_CH) begin
        push_header(flen + wvbh_pkg::SIMPLE_SIZE_ADD);
        phase = wvbh_pkg::PH_SIMPLE;
      end else begin
        phase = wvbh_pkg::PH_COUNT;
      end
    end
    case (phase)
      wvbh_pkg::PH_SIMPLE: begin
        if (seen < 4) samples |= 32'(b) << (8 * seen);
        push_byte(b, 1'b0);
        seen++;
        if (seen == flen) finish_frame();
      end
      wvbh_pkg::PH_COUNT: begin
        samples |= 32'(b) << (8 * seen);
        seen++;
        if (seen == 4) after_block();
      end
      wvbh_pkg::PH_TRIPLE: begin
        k = left;
        if (k < 4) flags |= 32'(b) << (8 * k);
        else if (k < 8) crc |= 32'(b) << (8 * (k - 4));
        else sub_size |= 32'(b) << (8 * ((k - 8) & 3));
        left++;
        seen++;
        if (left == 32'(wvbh_pkg::TRIPLE_BYTES)) begin
          rem = flen - seen;
          if (sub_size == 0 || rem < sub_size) begin
            fail_frame();
          end else begin
            push_header(sub_size + wvbh_pkg::MULTI_SIZE_ADD);
            push_word(samples);
            push_word(flags);
            push_word(crc);
            left = sub_size;
            phase = wvbh_pkg::PH_PAYLOAD;
          end
        end
      end
      wvbh_pkg::PH_PAYLOAD: begin
        push_byte(b, 1'b0);
        left--;
        seen++;
        if (left == 0) after_block();
      end
      wvbh_pkg::PH_DROP: begin
        seen++;
        if (seen == flen) finish_frame();
      end
      default: ;
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) rebuilt_q.push_back(burst[i]);
  endfunction

  // Input, configuration and output are all handled here so that the
  // expectations of an item are in place before any of its results is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == wvbh_pkg::REG_CODEC_VERSION) version = cfg.data;
        else if (cfg.index == wvbh_pkg::REG_CHANNEL_COUNT) chans = cfg.data[7:0];
      end
      if (din.valid && din.ready) begin
        rebuild_step(din.in_byte, din.frame_start, din.frame_bytes);
        bytes_in++;
      end
      if (dout.valid && dout.ready) begin
        got = '{data: dout.out_byte, err: dout.is_error, last: dout.run_last};
        bytes_out++;
        if (got.err === 1'b1) error_items++;
        if (rebuilt_q.size() == 0) begin
          $error("out_byte 0x%02h arrived with no result expected", got.data);
          fail_count++;
        end else begin
          want = rebuilt_q.pop_front();
          if (got.data !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, got.data);
            fail_count++;
          end
          if (got.err !== want.err) begin
            $error("is_error: expected %0b, got %0b", want.err, got.err);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, got.last);
            fail_count++;
          end
        end
      end
      if ((din.valid && din.ready) || (dout.valid && dout.ready) || (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timed out after %0d cycles with nothing accepted.", quiet);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      dout.ready <= 1'b0;
    end else begin
      dout.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st,
                           input logic [FLB-1:0] fb);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      din.valid <= 1'b0;
      @(negedge clk);
    end
    din.valid       <= 1'b1;
    din.in_byte     <= b;
    din.frame_start <= st;
    din.frame_bytes <= fb;
    do @(posedge clk); while (!din.ready);
  endtask

  // Sends the first n bytes of the frame buffer, fb as the length on the first.
  task automatic send_frame(input logic [FLB-1:0] fb, input int n);
    for (int i = 0; i < n; i++)
      send_byte(frame_buf[i], i == 0, (i == 0) ? fb : FLB'($urandom));
    frames_sent++;
  endtask

  task automatic send_whole_frame();
    send_frame(FLB'(frame_buf.size()), frame_buf.size());
  endtask

  task automatic send_stray(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0, FLB'($urandom));
  endtask

  function automatic void add_bytes(input int n);
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
  endfunction

  function automatic void add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) frame_buf.push_back(w[8*i +: 8]);
  endfunction

  function automatic void add_triple(input logic [31:0] size);
    add_word($urandom);
    add_word($urandom);
    add_word(size);
  endfunction

  // The sender waits here until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    din.valid <= 1'b0;
    while (rebuilt_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wvbh_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [wvbh_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] ver, input logic [7:0] ch);
    drain();
    write_reg(wvbh_pkg::REG_CODEC_VERSION, ver);
    // Only the low byte counts for the channel count; the upper byte is noise.
    write_reg(wvbh_pkg::REG_CHANNEL_COUNT, {8'($urandom), ch});
  endtask

  task automatic send_good_frame();
    int n_sub, size;
    frame_buf.delete();
    if (chans <= wvbh_pkg::SIMPLE_MAX_CH) begin
      add_bytes($urandom_range(4, 24));
    end else begin
      add_word($urandom);
      n_sub = $urandom_range(1, 3);
      for (int i = 0; i < n_sub; i++) begin
        size = $urandom_range(1, 8);
        add_triple(size);
        add_bytes(size);
      end
      if ($urandom_range(1)) add_bytes($urandom_range(1, 12));
    end
    send_whole_frame();
  endtask

  task automatic send_bad_size_frame();
    int extra, pick;
    logic [31:0] size;
    frame_buf.delete();
    add_word($urandom);
    if ($urandom_range(1)) begin
      size = $urandom_range(1, 6);
      add_triple(size);
      add_bytes(size);
    end
    extra = $urandom_range(0, 8);
    pick = $urandom_range(2);
    if (pick == 0) size = '0;
    else if (pick == 1) size = extra + 1;
    else size = $urandom | 32'h8000_0000;
    add_triple(size);
    add_bytes(extra);
    send_whole_frame();
  endtask

  task automatic send_truncated_frame();
    int n;
    frame_buf.delete();
    add_word($urandom);
    add_triple(32'd8);
    add_bytes(8);
    n = $urandom_range(1, frame_buf.size() - 1);
    send_frame($urandom_range(1) ? FLB'(frame_buf.size()) : FLB'($urandom), n);
  endtask

  task automatic test_simple_mode();
    frame_buf.delete();
    add_bytes(3);
    send_frame(24'd0, 1);
    send_stray(2);
    send_frame(24'd3, 3);
    frame_buf = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    send_whole_frame();
    // A frame of the largest length, abandoned by the next frame start.
    frame_buf.delete();
    add_bytes(5);
    send_frame(24'hFF_FFFF, 5);
    frame_buf.delete();
    add_bytes(6);
    send_whole_frame();
  endtask

  task automatic test_multi_mode();
    set_config(16'h0000, 8'd3);
    frame_buf.delete();
    add_word(32'hFFFF_FFFF);
    send_whole_frame();
    frame_buf.delete();
    add_word($urandom);
    add_bytes(12);
    send_whole_frame();
    frame_buf.delete();
    add_word($urandom);
    add_triple(32'd1);
    add_bytes(1 + 3);
    send_whole_frame();
    // The second sub-block exactly fills what is left of the frame.
    frame_buf.delete();
    add_word($urandom);
    add_triple(32'd2);
    add_bytes(2);
    add_triple(32'd5);
    add_bytes(5);
    send_whole_frame();
    frame_buf.delete();
    add_word($urandom);
    add_triple(32'd0);
    add_bytes(2);
    send_whole_frame();
    frame_buf.delete();
    add_word($urandom);
    add_triple(32'd3);
    add_bytes(3);
    add_triple(32'hFFFF_FFFF);
    add_bytes(4);
    send_whole_frame();
    frame_buf.delete();
    add_word($urandom);
    add_triple(32'd5);
    add_bytes(4);
    send_whole_frame();
    frame_buf.delete();
    add_word($urandom);
    add_bytes(6);
    send_frame(24'hFF_FFFF, 10);
    send_good_frame();
  endtask

  task automatic test_backpressure();
    set_config(16'($urandom), 8'd4);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    frame_buf.delete();
    add_word($urandom);
    add_triple(32'd24);
    add_bytes(24);
    add_triple(32'd24);
    add_bytes(24);
    // The receiver holds off long enough for the header burst to stall the input.
    rx_hold = 300;
    send_whole_frame();
    drain();
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input logic [15:0] ver, input logic [7:0] ch);
    int first, pick;
    set_config(ver, ch);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    first = bytes_in;
    while (bytes_in - first < 10) begin
      pick = $urandom_range(99);
      if (pick < 70) send_good_frame();
      else if (pick < 78) begin
        frame_buf.delete();
        add_bytes(1);
        send_frame(FLB'($urandom_range(0, 3)), 1);
        send_stray($urandom_range(0, 3));
      end
      else if (pick < 86) send_bad_size_frame();
      else if (pick < 93) send_truncated_frame();
      else send_stray($urandom_range(1, 4));
    end
    // Leave the parser idle before the registers are next written.
    send_good_frame();
  endtask

  initial begin
    rst = 1'b1;
    din.valid = 1'b0;
    din.in_byte = '0;
    din.frame_start = 1'b0;
    din.frame_bytes = '0;
    dout.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    version = wvbh_pkg::CODEC_VERSION_RST;
    chans = wvbh_pkg::CHANNEL_COUNT_RST;
    blk_index = '0;
    samples = '0;
    flags = '0;
    crc = '0;
    sub_size = '0;
    left = '0;
    seen = '0;
    flen = '0;
    phase = wvbh_pkg::PH_IDLE;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    rx_hold = 0;
    quiet = 0;
    fail_count = 0;
    bytes_in = 0;
    bytes_out = 0;
    error_items = 0;
    frames_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_simple_mode();
    test_multi_mode();
    test_backpressure();
    test_random_traffic(0, 0, 16'hFFFF, 8'd255);
    test_random_traffic(53, 0, 16'($urandom), 8'd1);
    test_random_traffic(0, 53, 16'($urandom), 8'd3);
    test_random_traffic(38, 38, 16'($urandom), 8'd2);
    drain();
    repeat (64) @(posedge clk);

    $display("Sent %0d frames (%0d bytes) in simple and multi-block mode; checked %0d bytes,",
             frames_sent, bytes_in, bytes_out);
    $display("%0d of them error items, under sender gaps, receiver stalls and a long hold-off.",
             error_items);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
